FILE: hw/rtl/srpt_preemptive_scheduler_assert.svh
// Assertion macros shared by the scheduler modules
`ifndef SRPT_PREEMPTIVE_SCHEDULER_ASSERT_SVH
`define SRPT_PREEMPTIVE_SCHEDULER_ASSERT_SVH

// Check an implication on every clock edge outside reset
`define SRPT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("srpt assertion failed");

// Check an implication whose consequent must hold in the next cycle
`define SRPT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("srpt assertion failed");

`endif

FILE: hw/rtl/srpt_pkg.sv
package srpt_pkg;

    localparam int unsigned IdW   = 16;
    localparam int unsigned TimeW = 32;
    localparam logic [TimeW-1:0] TimeMax = '1;

    typedef struct packed {
        logic [IdW-1:0]   job_id;
        logic [TimeW-1:0] release_time;
        logic [TimeW-1:0] processing_time;
        logic             last_job;
    } in_req_t;

    typedef struct packed {
        logic [IdW-1:0]   seg_job;
        logic [TimeW-1:0] seg_start;
        logic [TimeW-1:0] seg_end;
        logic             job_done;
        logic             status;
        logic             last_result;
    } out_req_t;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_LOAD    = 3'd1,
        OP_RUN     = 3'd2,
        OP_INSERT  = 3'd3,
        OP_DROP    = 3'd4,
        OP_DRAIN   = 3'd5
    } op_t;

    typedef struct packed {
        op_t  op;
        logic emit_last;
    } cmd_t;

    typedef struct packed {
        logic queue_empty;
        logic queue_full;
        logic reached;
        logic last_job;
    } stat_t;

endpackage

FILE: hw/rtl/srpt_datapath.sv
module srpt_datapath #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  srpt_pkg::in_req_t in_req,
    input  srpt_pkg::cmd_t    cmd,
    output srpt_pkg::stat_t   stat,
    output srpt_pkg::out_req_t res
);
    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned TW   = srpt_pkg::TimeW;

    // Sorted queue in a register row, head at index 0
    logic [TW-1:0]           rem_reg [QUEUE_DEPTH];
    logic [TW-1:0]           rem_next[QUEUE_DEPTH];
    logic [srpt_pkg::IdW-1:0] id_reg [QUEUE_DEPTH];
    logic [srpt_pkg::IdW-1:0] id_next[QUEUE_DEPTH];
    logic [CntW-1:0] count_reg, count_next;
    logic [TW-1:0]   time_reg, time_next;
    srpt_pkg::in_req_t   job_reg, job_next;
    srpt_pkg::out_req_t  res_reg, res_next;

    logic [TW-1:0] gap;
    logic [TW:0]   sum;
    logic          fits;
    logic [QUEUE_DEPTH-1:0] le;
    logic [QUEUE_DEPTH-1:0] le_prev;

    assign gap = job_reg.release_time - time_reg;
    assign sum = {1'b0, time_reg} + {1'b0, rem_reg[0]};
    assign fits = rem_reg[0] <= gap;

    // Per-slot compare for the sorted insert
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            le[i] = (CntW'(i) < count_reg) && (rem_reg[i] <= job_reg.processing_time);
        end
    end

    // Compare result of the slot below, slot 0 sees an open boundary
    assign le_prev = {le[QUEUE_DEPTH-2:0], 1'b1};

    always_comb begin
        rem_next   = rem_reg;
        id_next    = id_reg;
        count_next = count_reg;
        time_next  = time_reg;
        job_next   = job_reg;
        res_next   = res_reg;
        case (cmd.op)
            srpt_pkg::OP_LOAD: begin
                job_next = in_req;
                if (in_req.release_time < time_reg) begin
                    job_next.release_time = time_reg;
                end
            end
            srpt_pkg::OP_RUN: begin
                res_next.seg_job     = id_reg[0];
                res_next.seg_start   = time_reg;
                res_next.status      = 1'b0;
                res_next.last_result = cmd.emit_last;
                if (fits) begin
                    res_next.seg_end  = sum[TW-1:0];
                    res_next.job_done = 1'b1;
                    time_next         = sum[TW-1:0];
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                        rem_next[i] = rem_reg[i+1];
                        id_next[i]  = id_reg[i+1];
                    end
                    count_next = count_reg - 1'b1;
                end else begin
                    res_next.seg_end  = job_reg.release_time;
                    res_next.job_done = 1'b0;
                    rem_next[0]       = rem_reg[0] - gap;
                    time_next         = job_reg.release_time;
                end
            end
            srpt_pkg::OP_INSERT: begin
                time_next = job_reg.release_time;
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if (!le[i] && CntW'(i) <= count_reg) begin
                        if (le_prev[i]) begin
                            rem_next[i] = job_reg.processing_time;
                            id_next[i]  = job_reg.job_id;
                        end else begin
                            rem_next[i] = rem_reg[i-1];
                            id_next[i]  = id_reg[i-1];
                        end
                    end
                end
                count_next = count_reg + 1'b1;
            end
            srpt_pkg::OP_DROP: begin
                time_next            = job_reg.release_time;
                res_next.seg_job     = job_reg.job_id;
                res_next.seg_start   = job_reg.release_time;
                res_next.seg_end     = job_reg.release_time;
                res_next.job_done    = 1'b0;
                res_next.status      = 1'b1;
                res_next.last_result = cmd.emit_last;
            end
            srpt_pkg::OP_DRAIN: begin
                res_next.seg_job     = id_reg[0];
                res_next.seg_start   = time_reg;
                res_next.seg_end     = sum[TW] ? srpt_pkg::TimeMax : sum[TW-1:0];
                res_next.job_done    = 1'b1;
                res_next.status      = 1'b0;
                res_next.last_result = cmd.emit_last;
                time_next            = res_next.seg_end;
                for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                    rem_next[i] = rem_reg[i+1];
                    id_next[i]  = id_reg[i+1];
                end
                count_next = count_reg - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Hold control state under reset, payload free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            time_reg  <= '0;
        end else begin
            count_reg <= count_next;
            time_reg  <= time_next;
        end
        rem_reg <= rem_next;
        id_reg  <= id_next;
        job_reg <= job_next;
        res_reg <= res_next;
    end

    assign res              = res_reg;
    assign stat.queue_empty = count_reg == '0;
    assign stat.queue_full  = count_reg >= CntW'(QUEUE_DEPTH);
    assign stat.reached     = time_reg >= job_reg.release_time;
    assign stat.last_job    = job_reg.last_job;

    `include "srpt_preemptive_scheduler_assert.svh"
    `SRPT_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CntW'(QUEUE_DEPTH))
    `SRPT_ASSERT_IMP(a_no_pop_empty, aclk, aresetn, cmd.op == srpt_pkg::OP_DRAIN, count_reg != '0)
    `SRPT_ASSERT_IMP(a_no_ins_full, aclk, aresetn, cmd.op == srpt_pkg::OP_INSERT, count_reg < CntW'(QUEUE_DEPTH))
endmodule

FILE: hw/rtl/srpt_ctrl.sv
module srpt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  srpt_pkg::stat_t stat,
    output srpt_pkg::cmd_t  cmd
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ADV   = 5'b00010,
        ST_PLACE = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_WAIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   mv_reg, mv_next;
    logic   slot_free;
    logic   emits;

    // Output register frees once taken
    assign slot_free = !mv_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        mv_next       = mv_reg && !m_ready;
        cmd.op        = srpt_pkg::OP_NONE;
        cmd.emit_last = 1'b0;
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = srpt_pkg::OP_LOAD;
                    state_next = ST_ADV;
                end
            end
            ST_ADV: begin
                if (stat.queue_empty || stat.reached) begin
                    state_next = ST_PLACE;
                end else if (slot_free) begin
                    cmd.op  = srpt_pkg::OP_RUN;
                    mv_next = 1'b1;
                end
            end
            ST_PLACE: begin
                if (!stat.queue_full) begin
                    cmd.op     = srpt_pkg::OP_INSERT;
                    state_next = stat.last_job ? ST_DRAIN : ST_WAIT;
                end else if (slot_free) begin
                    cmd.op        = srpt_pkg::OP_DROP;
                    cmd.emit_last = !stat.last_job;
                    mv_next       = 1'b1;
                    state_next    = stat.last_job ? ST_DRAIN : ST_WAIT;
                end
            end
            ST_DRAIN: begin
                if (stat.queue_empty) begin
                    state_next = ST_WAIT;
                end else if (slot_free) begin
                    cmd.op  = srpt_pkg::OP_DRAIN;
                    mv_next = 1'b1;
                end
            end
            ST_WAIT: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Advance the state and the result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_valid = mv_reg;

    // Operations that load the result register
    assign emits = (cmd.op == srpt_pkg::OP_RUN) || (cmd.op == srpt_pkg::OP_DROP)
                   || (cmd.op == srpt_pkg::OP_DRAIN);

    `include "srpt_preemptive_scheduler_assert.svh"
    `SRPT_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_ready, !mv_reg || state_reg == ST_IDLE)
    `SRPT_ASSERT_NEXT(a_hold_valid, aclk, aresetn, mv_reg && !m_ready, mv_reg)
    `SRPT_ASSERT_IMP(a_emit_free, aclk, aresetn, emits, slot_free)
endmodule

FILE: hw/rtl/srpt_preemptive_scheduler.sv
// Channel | Ports                      | Moves
// input   | s_valid s_ready s_req      | one job arrival request
// result  | m_valid m_ready m_req      | one segment or drop request
// An arrival steps through accept, reach release (emitting run segments),
// place and wait; a last job also drains the queue job by job and then sees
// it empty. A drop is made in the place state. Up to QUEUE_DEPTH + 2 results.
// Reset (aresetn low, synchronous) empties the queue and zeroes time.
// A stalled result holds the scheduler; the final result of a request waits
// in a trailing buffer stage and holds off the next request until taken.
module srpt_preemptive_scheduler #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  srpt_pkg::in_req_t  s_req,
    output logic               m_valid,
    input  logic               m_ready,
    output srpt_pkg::out_req_t m_req
);
    srpt_pkg::cmd_t     cmd;
    srpt_pkg::stat_t    stat;
    srpt_pkg::out_req_t dp_res;
    logic               dp_valid, dp_ready;
    logic               hold_reg, hold_next;
    srpt_pkg::out_req_t buf_reg, buf_next;
    logic               idle_in;
    logic               ctrl_ready;
    logic               buf_clear;
    logic               ctrl_valid;

    // Accept a new request only once the buffered final result leaves
    assign buf_clear  = !hold_reg || m_ready;
    assign s_ready    = ctrl_ready && buf_clear;
    assign ctrl_valid = s_valid && buf_clear;

    srpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (ctrl_valid),
        .s_ready (ctrl_ready),
        .m_valid (dp_valid),
        .m_ready (dp_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    srpt_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_req  (s_req),
        .cmd     (cmd),
        .stat    (stat),
        .res     (dp_res)
    );

    // One-deep delay buffer: a result is released when the next one of the
    // same request arrives, or marked last once the request has finished.
    assign idle_in = ctrl_ready && !dp_valid;
    always_comb begin
        hold_next = hold_reg;
        buf_next  = buf_reg;
        m_valid   = 1'b0;
        m_req     = buf_reg;
        dp_ready  = 1'b0;
        if (hold_reg && (dp_valid || idle_in)) begin
            m_valid = 1'b1;
            m_req.last_result = !dp_valid;
        end
        if (!hold_reg) begin
            dp_ready = 1'b1;
            if (dp_valid) begin
                hold_next = 1'b1;
                buf_next  = dp_res;
            end
        end else if (m_valid && m_ready) begin
            dp_ready  = 1'b1;
            hold_next = dp_valid;
            if (dp_valid) begin
                buf_next = dp_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 1'b0;
        end else begin
            hold_reg <= hold_next;
        end
        buf_reg <= buf_next;
    end
endmodule

FILE: tb/sv/srpt_preemptive_scheduler_test.sv
`timescale 1ns / 100ps

module srpt_preemptive_scheduler_test;

    localparam int unsigned QDEPTH = 16;
    localparam int unsigned IDLE_LIMIT = 4000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    srpt_pkg::in_req_t  s_req;
    logic     m_valid;
    logic     m_ready;
    srpt_pkg::out_req_t m_req;

    srpt_preemptive_scheduler #(.QUEUE_DEPTH(QDEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req(s_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_req(m_req)
    );

    // scheduler shadow state
    logic [srpt_pkg::TimeW-1:0] sched_rem [QDEPTH];
    logic [srpt_pkg::IdW-1:0]   sched_id [QDEPTH];
    int unsigned      sched_count;
    logic [srpt_pkg::TimeW-1:0] sched_now;

    srpt_pkg::in_req_t  arrivals_pending[$];
    srpt_pkg::out_req_t segments_expected[$];
    int       mismatch_count = 0;
    int       idle_cycles;
    bit       stim_done;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void push_segment(logic [srpt_pkg::IdW-1:0] job,
                                         logic [srpt_pkg::TimeW-1:0] s,
                                         logic [srpt_pkg::TimeW-1:0] e, logic done, logic st);
        srpt_pkg::out_req_t r;
        r.seg_job = job;
        r.seg_start = s;
        r.seg_end = e;
        r.job_done = done;
        r.status = st;
        r.last_result = 1'b0;
        segments_expected.push_back(r);
    endfunction

    function automatic void pop_shortest();
        for (int i = 1; i < sched_count; i++) begin
            sched_rem[i-1] = sched_rem[i];
            sched_id[i-1] = sched_id[i];
        end
        if (sched_count > 0) sched_count--;
    endfunction

    // schedule one arrival and queue its segments
    function automatic void schedule_arrival(srpt_pkg::in_req_t a);
        logic [srpt_pkg::TimeW-1:0] rel;
        logic [srpt_pkg::TimeW-1:0] rem;
        logic [srpt_pkg::TimeW-1:0] fin;
        int unsigned pos;
        int before_n;
        before_n = segments_expected.size();
        rel = (a.release_time < sched_now) ? sched_now : a.release_time;
        while (sched_count > 0 && sched_now < rel) begin
            rem = sched_rem[0];
            if (rem <= rel - sched_now) begin
                push_segment(sched_id[0], sched_now, sched_now + rem, 1'b1, 1'b0);
                sched_now = sched_now + rem;
                pop_shortest();
            end else begin
                push_segment(sched_id[0], sched_now, rel, 1'b0, 1'b0);
                sched_rem[0] = rem - (rel - sched_now);
                sched_now = rel;
            end
        end
        sched_now = rel;
        if (sched_count >= QDEPTH) begin
            push_segment(a.job_id, sched_now, sched_now, 1'b0, 1'b1);
        end else begin
            pos = 0;
            while (pos < sched_count && sched_rem[pos] <= a.processing_time) pos++;
            for (int i = sched_count; i > pos; i--) begin
                sched_rem[i] = sched_rem[i-1];
                sched_id[i] = sched_id[i-1];
            end
            sched_rem[pos] = a.processing_time;
            sched_id[pos] = a.job_id;
            sched_count++;
        end
        if (a.last_job) begin
            while (sched_count > 0) begin
                rem = sched_rem[0];
                fin = (rem > srpt_pkg::TimeMax - sched_now) ? srpt_pkg::TimeMax
                                                             : sched_now + rem;
                push_segment(sched_id[0], sched_now, fin, 1'b1, 1'b0);
                sched_now = fin;
                pop_shortest();
            end
        end
        if (segments_expected.size() > before_n)
            segments_expected[segments_expected.size()-1].last_result = 1'b1;
    endfunction

    function automatic srpt_pkg::in_req_t make_arrival(logic [srpt_pkg::IdW-1:0] id,
                                                       logic [srpt_pkg::TimeW-1:0] rel,
                                                       logic [srpt_pkg::TimeW-1:0] pt,
                                                       logic last);
        srpt_pkg::in_req_t a;
        a.job_id = id;
        a.release_time = rel;
        a.processing_time = pt;
        a.last_job = last;
        return a;
    endfunction

    // stimulus
    initial begin
        logic [srpt_pkg::TimeW-1:0] t;
        int n;
        int burst;
        stim_done = 1'b0;
        // early release, zero time, ties, full queue, drain
        arrivals_pending.push_back(make_arrival(16'h0000, 32'd10, 32'd5, 1'b0));
        arrivals_pending.push_back(make_arrival(16'hFFFF, 32'd12, 32'd1, 1'b0));
        arrivals_pending.push_back(make_arrival(16'h1234, 32'd3, 32'd0, 1'b0));
        arrivals_pending.push_back(make_arrival(16'h0001, 32'd14, 32'd4, 1'b0));
        arrivals_pending.push_back(make_arrival(16'h0002, 32'd14, 32'd4, 1'b1));
        arrivals_pending.push_back(make_arrival(16'h0003, 32'd1000, 32'd7, 1'b0));
        for (int i = 0; i < 17; i++)
            arrivals_pending.push_back(make_arrival(16'(16'h0100 + i), 32'd1000,
                                                    32'(100 - i), i == 16));
        // random bursts that end in a drain, with early and late releases
        t = 32'd0;
        n = 0;
        while (n < 400) begin
            burst = $urandom_range(1, 22);
            for (int i = 0; i < burst; i++) begin
                srpt_pkg::in_req_t a;
                a.job_id = 16'($urandom);
                case ($urandom_range(0, 5))
                    0: a.release_time = $urandom;
                    1: a.release_time = t;
                    default: a.release_time = t + $urandom_range(0, 40);
                endcase
                if (a.release_time >= t) t = a.release_time;
                case ($urandom_range(0, 5))
                    0: a.processing_time = $urandom;
                    1: a.processing_time = 32'hFFFFFFFF - $urandom_range(0, 3);
                    2: a.processing_time = 0;
                    default: a.processing_time = $urandom_range(1, 30);
                endcase
                a.last_job = (i == burst - 1) || ($urandom_range(0, 15) == 0);
                arrivals_pending.push_back(a);
                n++;
            end
        end
        // time saturation at the top of the range
        arrivals_pending.push_back(make_arrival(16'h0200, 32'hFFFFFF00, 32'hFFFFFFFF, 1'b0));
        arrivals_pending.push_back(make_arrival(16'h0201, 32'hFFFFFF00, 32'd300, 1'b1));
        stim_done = 1'b1;
    end

    // driver: bursts with random gaps
    int gap_left;
    int burst_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_req <= '0;
            gap_left <= 0;
            burst_left <= $urandom_range(1, 8);
        end else if (!s_valid || s_ready) begin
            if (s_valid && burst_left > 1) burst_left <= burst_left - 1;
            if (s_valid && burst_left <= 1) begin
                s_valid <= 1'b0;
                gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 30);
                burst_left <= $urandom_range(1, 8);
            end else if (gap_left > 0) begin
                s_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (arrivals_pending.size() > 0) begin
                s_valid <= 1'b1;
                s_req <= arrivals_pending.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: alternate quiet and stalling stretches
    int stall_phase;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[8]) m_ready <= ($urandom_range(0, 2) != 0);
            else m_ready <= 1'b1;
        end
    end

    // monitor: predict on accepted requests, check results
    always @(posedge aclk) begin
        srpt_pkg::out_req_t want;
        if (!aresetn) begin
            idle_cycles <= 0;
            sched_count = 0;
            sched_now = '0;
        end else begin
            if (s_valid && s_ready) schedule_arrival(s_req);
            if (m_valid && m_ready) begin
                if (segments_expected.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %p", m_req);
                end else begin
                    want = segments_expected.pop_front();
                    if (m_req.seg_job !== want.seg_job || m_req.seg_start !== want.seg_start
                        || m_req.seg_end !== want.seg_end || m_req.job_done !== want.job_done
                        || m_req.status !== want.status
                        || m_req.last_result !== want.last_result) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("expected %p actual %p", want, m_req);
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // reset and end of run
    initial begin
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        while (!(stim_done && arrivals_pending.size() == 0 && !s_valid
                 && segments_expected.size() == 0) && idle_cycles < IDLE_LIMIT)
            @(posedge aclk);
        if (idle_cycles < IDLE_LIMIT) repeat (60) @(posedge aclk);
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("srpt_preemptive_scheduler: mismatch");
        end else if (mismatch_count == 0 && segments_expected.size() == 0) begin
            $display("srpt_preemptive_scheduler: match");
        end else begin
            $display("srpt_preemptive_scheduler: mismatch");
        end
        $finish;
    end

endmodule
